FILE: design/assert_macros.svh
// Assertion macros shared by the queue RTL, clocked on clk and reset by rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

FILE: design/spq_pkg.sv
// Types and constants of the stable priority task queue
package spq_pkg;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [7:0]  priority_req;
        logic [7:0]  task_id;
        logic [31:0] argument;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        popped_valid;
        logic [7:0]  out_priority;
        logic [7:0]  out_task_id;
        logic [31:0] out_argument;
        logic [4:0]  occupancy;
    } res_t;

    // one held task
    typedef struct packed {
        logic [7:0]  prio;
        logic [7:0]  task_id;
        logic [31:0] argument;
    } entry_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t entry;
    } cmd_t;

endpackage

FILE: design/stable_priority_task_queue.sv
// Top level of the stable priority task queue
//
// Command channel: a request (insert or pop) transfers at a rising edge with
// start high and busy low. busy never rises, so a request may be issued every
// cycle. Each request gives exactly one result, shown on result with done high
// for one cycle, in the cycle after the request transfer. The receiver cannot
// stall; a result must be taken in the cycle it is shown.
// Throughput is one request per cycle: every cell of
// the row compares its priority with the request and updates in parallel,
// so no walk over the entries is needed.
// Ties keep arrival order: an insert goes behind every held entry whose
// priority value is the same or lower. A full queue drops inserts and
// reports ST_FULL; a pop on an empty queue reports ST_EMPTY.
// Reset empties the queue (count to zero) and clears done; slot contents are
// left as they are and are never read before being written.
// occupancy reports the number of held tasks after the request, low 5 bits.
module stable_priority_task_queue #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t request,
    output logic          done,
    output spq_pkg::res_t result
);
    import spq_pkg::*;
`include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [7:0] PRIO_MASK =
        (PRIORITY_BITS >= 8) ? 8'hFF : 8'((1 << PRIORITY_BITS) - 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          done_next;
    res_t          result_reg;
    res_t          result_next;

    logic          accept;
    logic          full;
    logic          empty;
    cmd_t          cmd;
    logic [1:0]    status;
    logic [CW+4:0] occ_ext;

    entry_t        cells [DEPTH];
    logic          keep  [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    // decode the request into a row command
    always_comb
    begin
        cmd.ins            = 1'b0;
        cmd.pop            = 1'b0;
        cmd.entry.prio     = request.priority_req & PRIO_MASK;
        cmd.entry.task_id  = request.task_id;
        cmd.entry.argument = request.argument;
        status             = ST_OK;
        count_next         = count_reg;
        unique case (request.operation)
            OP_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.ins    = accept;
                    count_next = accept ? count_reg + CW'(1) : count_reg;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cmd.pop    = accept;
                    count_next = accept ? count_reg - CW'(1) : count_reg;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // row of cells, head at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (CW'(i) < count_reg),
            .left_keep   ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .left_entry  ((i == 0) ? cmd.entry : cells[(i == 0) ? 0 : i - 1]),
            .right_entry ((i == DEPTH - 1) ? cells[i]
                                           : cells[(i == DEPTH - 1) ? i : i + 1]),
            .keep        (keep[i]),
            .entry       (cells[i])
        );
    end

    // result word
    always_comb
    begin
        occ_ext                  = {5'b0, count_next};
        result_next              = '0;
        result_next.status       = status;
        result_next.popped_valid = cmd.pop;
        if (cmd.pop)
        begin
            result_next.out_priority = cells[0].prio;
            result_next.out_task_id  = cells[0].task_id;
            result_next.out_argument = cells[0].argument;
        end
        result_next.occupancy    = occ_ext[4:0];
        done_next                = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `ASSERT_CLK(a_done_follows_start, done |-> $past(accept))
    `ASSERT_NEVER(a_count_bound, count_reg > CW'(DEPTH))
    `ASSERT_CLK(a_count_quiet, !$past(accept) |-> $stable(count_reg))
    `ASSERT_CLK(a_pop_ok, (done && result.popped_valid) |-> (result.status == ST_OK))
    `ASSERT_CLK(a_full_drop, (done && result.status == ST_FULL) |-> (count_reg == CW'(DEPTH)))

endmodule

FILE: design/spq_cell.sv
// One slot of the sorted queue row: holds an entry and shifts it left or right
module spq_cell (
    input  logic           clk,
    input  spq_pkg::cmd_t  cmd,
    input  logic           occupied,
    input  logic           left_keep,
    input  spq_pkg::entry_t left_entry,
    input  spq_pkg::entry_t right_entry,
    output logic           keep,
    output spq_pkg::entry_t entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // held entry stays put on insert when it is not served later than the new one
    assign keep  = occupied && (entry_reg.prio <= cmd.entry.prio);
    assign entry = entry_reg;

    // insert: first non-kept slot takes the new entry, later ones shift right
    // pop: every slot takes its right neighbour
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !keep)
        begin
            entry_next = left_keep ? cmd.entry : left_entry;
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
